[hw/rtl/vts_pkg.sv]
package vts_pkg;

    // scan phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_V       = 3'd1;
    localparam logic [2:0] PH_VE      = 3'd2;
    localparam logic [2:0] PH_LETTERS = 3'd3;
    localparam logic [2:0] PH_SEPS    = 3'd4;
    localparam logic [2:0] PH_DIGITS  = 3'd5;
    localparam logic [2:0] PH_IGNORE  = 3'd7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;

    localparam logic [2:0] MAX_DIGITS   = 3'd3;
    localparam logic [9:0] MAX_VELOCITY = 10'd127;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    typedef struct packed {
        logic [2:0] phase;
        logic [2:0] count;
        logic [9:0] value;
        logic       found;
        logic [6:0] vel;
    } vts_state_t;

    localparam vts_state_t STATE_CLEAR = '{
        phase: PH_IDLE, count: 3'd0, value: 10'd0, found: 1'b0, vel: 7'd0
    };

    // digit run that closes with an acceptable value
    function automatic logic run_ok(input vts_state_t s);
        run_ok = (s.phase == PH_DIGITS) && (s.count >= 3'd1) && (s.count <= MAX_DIGITS)
              && (s.value >= 10'd1) && (s.value <= MAX_VELOCITY);
    endfunction

endpackage

[hw/rtl/velocity_tag_scanner_top.sv]
// the result is registered and shows on m_tvalid in the cycle after the final character's transfer
// throughput: one character per cycle, no stall unless the result is held back
// one result per filename, on the character that carries s_tlast
// reset: synchronous active-low aresetn clears the scan state and the output valid
module velocity_tag_scanner_top
    import vts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // character stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tlast,   // final_char
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] velocity, [7] zero fill
    output logic       m_tuser    // found
);

    vts_state_t state_reg;
    vts_state_t state_next;
    logic       step_found;
    logic [6:0] step_vel;
    logic       m_valid_reg;
    logic       m_found_reg;
    logic [6:0] m_vel_reg;
    logic       s_xfer;

    // the result register frees up when its transfer completes, so a new
    // character is taken in the same cycle the old result leaves
    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    // next scan state and the result a final character would produce
    vts_step u_step (
        .cur       (state_reg),
        .char_in   (s_tdata),
        .last_in   (s_tlast),
        .nxt       (state_next),
        .res_found (step_found),
        .res_vel   (step_vel)
    );

    // scan state advances on every character transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    // result register: valid is control, payload loads on the final character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && s_tlast) begin
            m_found_reg <= step_found;
            m_vel_reg   <= step_vel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_vel_reg};
    assign m_tuser  = m_found_reg;

endmodule

[hw/rtl/vts_step.sv]
module vts_step
    import vts_pkg::*;
(
    input  vts_state_t cur,
    input  logic [7:0] char_in,
    input  logic       last_in,
    output vts_state_t nxt,
    output logic       res_found,
    output logic [6:0] res_vel
);

    logic [7:0] low_c;
    logic       is_letter;
    logic       is_sep;
    logic       is_digit;
    logic [9:0] digit;
    logic [9:0] times_ten;
    logic [2:0] restart;
    vts_state_t mid;

    always_comb begin
        low_c     = (char_in inside {[CH_UA:CH_UZ]}) ? char_in + CASE_OFFSET : char_in;
        is_letter = low_c inside {[CH_LA:CH_LZ]};
        is_sep    = char_in inside {CH_UNDER, CH_DASH, CH_SPACE};
        is_digit  = char_in inside {[CH_ZERO:CH_NINE]};
        digit     = {2'b00, char_in - CH_ZERO};
        times_ten = {cur.value[6:0], 3'b000} + {cur.value[8:0], 1'b0};
        restart   = (low_c == CH_V) ? PH_V : PH_IDLE;
    end

    // one character of scanning
    always_comb begin
        mid = cur;
        if (cur.phase != PH_IGNORE) begin
            if (char_in == CH_NUL) begin
                if (run_ok(cur)) begin
                    mid.found = 1'b1;
                    mid.vel   = cur.value[6:0];
                end
                mid.phase = PH_IGNORE;
            end else begin
                case (cur.phase)
                    PH_DIGITS: begin
                        if (is_digit) begin
                            if (cur.count >= MAX_DIGITS) begin
                                mid.phase = PH_IDLE;
                            end else begin
                                mid.value = times_ten + digit;
                                mid.count = cur.count + 3'd1;
                            end
                        end else begin
                            if (run_ok(cur)) begin
                                mid.found = 1'b1;
                                mid.vel   = cur.value[6:0];
                            end
                            mid.phase = restart;
                        end
                    end
                    PH_SEPS: begin
                        if (is_sep) begin
                            mid.phase = PH_SEPS;
                        end else if (is_digit) begin
                            mid.phase = PH_DIGITS;
                            mid.count = 3'd1;
                            mid.value = digit;
                        end else begin
                            mid.phase = restart;
                        end
                    end
                    PH_LETTERS: begin
                        if (is_letter) begin
                            mid.phase = PH_LETTERS;
                        end else if (is_sep) begin
                            mid.phase = PH_SEPS;
                        end else if (is_digit) begin
                            mid.phase = PH_DIGITS;
                            mid.count = 3'd1;
                            mid.value = digit;
                        end else begin
                            mid.phase = restart;
                        end
                    end
                    PH_VE: begin
                        mid.phase = (low_c == CH_L) ? PH_LETTERS : restart;
                    end
                    PH_V: begin
                        mid.phase = (low_c == CH_E) ? PH_VE : restart;
                    end
                    default: begin
                        mid.phase = restart;
                    end
                endcase
            end
        end
    end

    // final character closes the open run and clears the scan state
    always_comb begin
        res_found = mid.found || run_ok(mid);
        res_vel   = run_ok(mid) ? mid.value[6:0] : (mid.found ? mid.vel : 7'd0);
        nxt       = last_in ? STATE_CLEAR : mid;
    end

endmodule

[hw/rtl/vts_checker.sv]
module vts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // no velocity without a found flag, and never above 127
    a_vel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
        else $error("velocity nonzero while not found");

    a_vel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == 1'b0))
        else $error("velocity above 127");

    // a final character transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("missing result after final character");

    // a new result only comes from a final character transfer
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !($past(m_tvalid) && !$past(m_tready)))
            |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without final character");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind velocity_tag_scanner_top vts_checker u_vts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/tb_velocity_tag_scanner_top.sv]
module tb_velocity_tag_scanner_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vts_pkg::*;

    // cycles without any transfer on either side before the run is abandoned
    localparam int IDLE_LIMIT = 4000;

    // one filename result as the block reports it
    typedef struct packed {
        logic       found;
        logic [6:0] velocity;
    } tag_result_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] character
    logic       s_tlast;   // final_char
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [6:0] velocity, [7] zero fill
    logic       m_tuser;   // found

    velocity_tag_scanner_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // results predicted for filenames already accepted, oldest first
    tag_result_t pending_results[$];

    // predicted scanner state
    logic [2:0] scan_ph  = PH_IDLE;
    logic [2:0] run_len  = 3'd0;
    logic [9:0] run_val  = 10'd0;
    logic       have_vel = 1'b0;
    logic [6:0] best_vel = 7'd0;

    // idling knobs, changed between tests
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;

    int errors      = 0;
    int chars_sent  = 0;
    int names_done  = 0;
    int found_count = 0;
    int checked     = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    // scratch filename built by the random generator
    logic [7:0] name_buf[$];

    // ---------------------------------------------------------------
    // character classes
    // ---------------------------------------------------------------
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        fold_case = (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFFSET : c;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        logic [7:0] low;
        low = fold_case(c);
        is_alpha = (low >= CH_LA && low <= CH_LZ);
    endfunction

    function automatic bit is_separator(input logic [7:0] c);
        is_separator = (c == CH_UNDER || c == CH_DASH || c == CH_SPACE);
    endfunction

    function automatic bit is_numeral(input logic [7:0] c);
        is_numeral = (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    // close the digit run in progress, keep it if it is a legal velocity
    task automatic settle_run();
        if (scan_ph == PH_DIGITS && run_len >= 3'd1 && run_len <= MAX_DIGITS
            && run_val >= 10'd1 && run_val <= MAX_VELOCITY) begin
            have_vel = 1'b1;
            best_vel = run_val[6:0];
        end
    endtask

    task automatic open_run(input logic [7:0] c);
        scan_ph = PH_DIGITS;
        run_len = 3'd1;
        run_val = {2'b00, c - CH_ZERO};
    endtask

    task automatic step_scan(input logic [7:0] c);
        logic [7:0] low;
        bit         handled;
        int         acc;
        low     = fold_case(c);
        handled = 1'b0;
        case (scan_ph)
            PH_DIGITS: begin
                if (is_numeral(c)) begin
                    // a fourth digit throws the whole run away
                    if (run_len >= MAX_DIGITS) begin
                        scan_ph = PH_IDLE;
                    end else begin
                        acc     = run_val * 10 + (c - CH_ZERO);
                        run_val = acc[9:0];
                        run_len = run_len + 3'd1;
                    end
                    handled = 1'b1;
                end else begin
                    settle_run();
                end
            end
            PH_SEPS: begin
                if (is_separator(c)) begin
                    handled = 1'b1;
                end else if (is_numeral(c)) begin
                    open_run(c);
                    handled = 1'b1;
                end
            end
            PH_LETTERS: begin
                if (is_alpha(c)) begin
                    handled = 1'b1;
                end else if (is_separator(c)) begin
                    scan_ph = PH_SEPS;
                    handled = 1'b1;
                end else if (is_numeral(c)) begin
                    open_run(c);
                    handled = 1'b1;
                end
            end
            PH_VE: begin
                if (low == CH_L) begin
                    scan_ph = PH_LETTERS;
                    handled = 1'b1;
                end
            end
            PH_V: begin
                if (low == CH_E) begin
                    scan_ph = PH_VE;
                    handled = 1'b1;
                end
            end
            default: ;
        endcase
        // anything unmatched restarts the tag search, a 'v' starts a new one
        if (!handled)
            scan_ph = (low == CH_V) ? PH_V : PH_IDLE;
    endtask

    task automatic track_char(input logic [7:0] c, input logic last);
        tag_result_t r;
        if (scan_ph != PH_IGNORE) begin
            // a nul byte ends the name, the rest up to tlast is dead
            if (c == CH_NUL) begin
                settle_run();
                scan_ph = PH_IGNORE;
            end else begin
                step_scan(c);
            end
        end
        if (last) begin
            settle_run();
            r.found    = have_vel;
            r.velocity = have_vel ? best_vel : 7'd0;
            pending_results.push_back(r);
            names_done++;
            if (have_vel)
                found_count++;
            scan_ph  = PH_IDLE;
            run_len  = 3'd0;
            run_val  = 10'd0;
            have_vel = 1'b0;
            best_vel = 7'd0;
        end
    endtask

    // input side monitor: every accepted character feeds the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            track_char(s_tdata, s_tlast);
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want, checked);
        errors++;
    endtask

    always @(posedge aclk) begin
        tag_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, found", m_tuser, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.found)
                    report_mismatch("found", m_tuser, want.found);
                if (m_tdata[6:0] !== want.velocity)
                    report_mismatch("velocity", m_tdata[6:0], want.velocity);
                if (m_tdata[7] !== 1'b0)
                    report_mismatch("tdata fill bit", m_tdata[7], 0);
            end
            checked++;
        end
    end

    // watchdog on cycles in which nothing transfers
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // idling
    // ---------------------------------------------------------------
    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            pick_gap = 0;
        else if (r < 92)
            pick_gap = $urandom_range(1, 3);
        else
            pick_gap = $urandom_range(8, 30);
    endfunction

    // receiver backpressure, changes at the falling edge
    always @(negedge aclk) begin
        int r;
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 9) < 3) begin
            m_tready <= 1'b0;
            r = $urandom_range(0, 9);
            stall_left = (r < 8) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // sending
    // ---------------------------------------------------------------
    // entered and left at a falling edge; tvalid stays high across
    // back-to-back transfers
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit end_name);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_name && (i == s.len() - 1));
    endtask

    task automatic send_buffer();
        for (int i = 0; i < name_buf.size(); i++)
            send_char(name_buf[i], i == name_buf.size() - 1);
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // random filename generator
    // ---------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        logic [7:0] c;
        c = 8'($urandom_range(CH_LA, CH_LZ));
        if ($urandom_range(0, 1))
            c = c - CASE_OFFSET;
        rand_letter = c;
    endfunction

    function automatic logic [7:0] rand_separator();
        case ($urandom_range(0, 2))
            0:       rand_separator = CH_UNDER;
            1:       rand_separator = CH_DASH;
            default: rand_separator = CH_SPACE;
        endcase
    endfunction

    task automatic push_tag();
        logic [7:0] tag[3];
        tag[0] = CH_V;
        tag[1] = CH_E;
        tag[2] = CH_L;
        // now and then a broken tag: one letter swapped for a random one
        if ($urandom_range(0, 7) == 0)
            tag[2'($urandom_range(0, 2))] = rand_letter();
        for (int i = 0; i < 3; i++)
            name_buf.push_back(($urandom_range(0, 1) && is_alpha(tag[i]))
                               ? fold_case(tag[i]) - CASE_OFFSET : fold_case(tag[i]));
    endtask

    // digit runs aimed at the edges: zero, 127/128, four digits
    task automatic push_digits();
        int ndig;
        int v;
        int div;
        ndig = $urandom_range(1, 4);
        if (ndig == 3 && $urandom_range(0, 1))
            v = $urandom_range(120, 135);
        else if (ndig == 4)
            v = $urandom_range(0, 9999);
        else
            v = $urandom_range(0, (ndig == 1) ? 9 : (ndig == 2) ? 99 : 999);
        div = (ndig == 1) ? 1 : (ndig == 2) ? 10 : (ndig == 3) ? 100 : 1000;
        repeat (ndig) begin
            name_buf.push_back(8'(CH_ZERO + (v / div) % 10));
            div = div / 10;
        end
    endtask

    task automatic build_name();
        int nseg;
        name_buf.delete();
        if ($urandom_range(0, 9) < 2) begin
            // noise: any byte value at all
            repeat ($urandom_range(1, 8))
                name_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            nseg = $urandom_range(1, 3);
            repeat (nseg) begin
                repeat ($urandom_range(0, 2))
                    name_buf.push_back($urandom_range(0, 1) ? rand_letter()
                                                            : 8'($urandom_range(8'h21, 8'h7e)));
                push_tag();
                repeat ($urandom_range(0, 2))
                    name_buf.push_back(rand_letter());
                repeat ($urandom_range(0, 2))
                    name_buf.push_back(rand_separator());
                push_digits();
            end
            // a trailing nul followed by junk that must be ignored
            if ($urandom_range(0, 9) == 0) begin
                name_buf.push_back(CH_NUL);
                repeat ($urandom_range(0, 3))
                    name_buf.push_back(8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 3) == 0) begin
                name_buf.push_back(rand_letter());
            end
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // hand-picked names for the edge cases
    task automatic test_directed_names();
        // upper case tag, underscore, largest velocity
        send_text("VEL_127", 1'b1);
        // four digits reject the run, high byte as the final character
        send_text("veL1234", 1'b0);
        send_char(8'hff, 1'b1);
        // restart on a second v, run closed by nul, later digits ignored
        send_text("vvel2", 1'b0);
        send_char(CH_NUL, 1'b0);
        send_char("3", 1'b1);
        // name that is nothing but a nul
        send_char(CH_NUL, 1'b1);
        // overlapping tag in the letters, then value above the limit
        send_text("velvel-128", 1'b1);
        // letters after the tag, space, value one on the final character
        send_text("Velo 1", 1'b1);
    endtask

    task automatic test_random_names(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            build_name();
            send_buffer();
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
    endtask

    // no gaps, no backpressure
    task automatic test_back_to_back_names(input int n_chars);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_names(n_chars);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // each name waits for the previous result to come back first
    task automatic test_drained_names(input int n_names);
        repeat (n_names) begin
            build_name();
            send_buffer();
            wait_drained();
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_names();
        test_random_names(600);
        test_back_to_back_names(300);
        test_drained_names(12);
        test_random_names(300);

        wait_drained();
        repeat (4) @(negedge aclk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("covered %0d filenames in %0d characters, %0d with a velocity found",
                 names_done, chars_sent, found_count);
        $display("random gaps and backpressure, back-to-back and drained phases, %0d checked",
                 checked);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule

[velocity_tag_scanner_top.f]
hw/rtl/vts_pkg.sv
hw/rtl/vts_step.sv
hw/rtl/velocity_tag_scanner_top.sv
hw/rtl/vts_checker.sv
sim/tb_velocity_tag_scanner_top.sv
